// ----- src/spm_pkg.sv -----
// Shared types and constants for the strobed mouse port.
package spm_pkg;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_STROBE = 2'd0,
      KIND_VSYNC  = 2'd1,
      KIND_MOVE   = 2'd2,
      KIND_BUTTON = 2'd3
   } kind_type;

   // Register indexes of the control port.
   localparam logic [1:0] CSR_JOYSTICK_MODE  = 2'd0;
   localparam logic [1:0] CSR_SENSITIVITY    = 2'd1;
   localparam logic [1:0] CSR_MOUSE_ATTACHED = 2'd2;
   localparam logic [1:0] CSR_PHASE_TIMEOUT  = 2'd3;

   localparam int CSR_DATA_WIDTH = 16;

   // Reset values of the control registers.
   localparam logic [6:0]  SENSITIVITY_RESET   = 7'd1;
   localparam logic [15:0] PHASE_TIMEOUT_RESET = 16'd72;

   // Byte constants.
   localparam logic [7:0] IDLE_BYTE    = 8'hFF;
   localparam logic [3:0] NIBBLE_FILL  = 4'hF;
   localparam logic [5:0] BUTTON_FILL  = 6'h3F;
   localparam int         STROBE_BIT   = 6;

   // Phase codes of the nibble sequence.
   localparam logic [1:0] PHASE_Y_LOW  = 2'd0;
   localparam logic [1:0] PHASE_X_HIGH = 2'd1;
   localparam logic [1:0] PHASE_X_LOW  = 2'd2;
   localparam logic [1:0] PHASE_Y_HIGH = 2'd3;

   // Control register set.
   typedef struct packed {
      logic        joystick_mode;
      logic [6:0]  sensitivity;
      logic        mouse_attached;
      logic [15:0] phase_timeout;
   } cfg_type;

   // One request as held in the input register.
   typedef struct packed {
      kind_type          kind;
      logic [7:0]        strobe_value;
      logic [31:0]       now;
      logic signed [7:0] move_x;
      logic signed [7:0] move_y;
      logic [1:0]        buttons;
   } item_type;

   // Port state carried from request to request.
   typedef struct packed {
      logic        strobe_level;
      logic [1:0]  phase;
      logic [31:0] start_time;
      logic [7:0]  held_x;
      logic [7:0]  held_y;
      logic [7:0]  joy_byte;
      logic        joy_valid;
   } state_type;

   localparam state_type STATE_RESET = '{
      strobe_level: 1'b0,
      phase:        PHASE_Y_LOW,
      start_time:   32'd0,
      held_x:       8'd0,
      held_y:       8'd0,
      joy_byte:     IDLE_BYTE,
      joy_valid:    1'b0
   };

endpackage

// ----- src/strobed_mouse_port.sv -----
// Top level of the strobed mouse port: input register, state, result register.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  kind, strobe_value, now, move_x/y, buttons
//   rsp_      out        rsp_valid / rsp_stall  read_data
//   csr_      in         csr_write              csr_index, csr_data
//
// A request is registered in the input register on acceptance and processed from
// there into the result register, where a read result is offered; one request
// per cycle is sustained unless a stalled result holds a read request back.
// Strobe and vsync requests produce no result and never wait on the result
// register. Reset is synchronous and restores the control registers, the valid
// flags and the port state. A stalled result holds the result register; a read
// request then waits in the input register and stalls the request side.
module strobed_mouse_port import spm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [7:0]                req_strobe_value,
   input  logic [31:0]               req_now,
   input  logic signed [7:0]         req_move_x,
   input  logic signed [7:0]         req_move_y,
   input  logic [1:0]                req_buttons,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_read_data,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       has_result;
   logic [7:0] read_data;
   logic       out_free;
   logic       fire;
   logic       req_take;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.joystick_mode  <= 1'b0;
         cfg_ff.sensitivity    <= SENSITIVITY_RESET;
         cfg_ff.mouse_attached <= 1'b1;
         cfg_ff.phase_timeout  <= PHASE_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_JOYSTICK_MODE:  cfg_ff.joystick_mode  <= csr_data[0];
            CSR_SENSITIVITY:    cfg_ff.sensitivity    <= csr_data[6:0];
            CSR_MOUSE_ATTACHED: cfg_ff.mouse_attached <= csr_data[0];
            CSR_PHASE_TIMEOUT:  cfg_ff.phase_timeout  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Request handshake: the held request fires unless it needs a busy result slot.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!has_result || out_free);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.kind         <= kind_type'(req_kind);
         item_ff.strobe_value <= req_strobe_value;
         item_ff.now          <= req_now;
         item_ff.move_x       <= req_move_x;
         item_ff.move_y       <= req_move_y;
         item_ff.buttons      <= req_buttons;
      end
   end

   spm_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .has_result (has_result),
      .read_data  (read_data)
   );

   // Port state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         rsp_data_ff <= read_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // A new result only ever comes from a processed read request.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && has_result))
      else $error("result appeared without a processed read request");

   // Port state changes only when a request is processed.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(fire)) |-> $stable(state_ff))
      else $error("port state changed without a processed request");

   // A vsync always forces a new joystick sample.
   a_vsync_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && item_ff.kind == KIND_VSYNC) |=> !state_ff.joy_valid)
      else $error("joystick sample still valid after vsync");

endmodule

// ----- src/spm_step.sv -----
// Combinational update of the port state and read data for one request.
module spm_step import spm_pkg::*; (
   input  cfg_type   cfg,
   input  state_type state,
   input  item_type  item,
   output state_type state_next,
   output logic      has_result,
   output logic [7:0] read_data
);

   logic              level;
   logic [31:0]       elapsed;
   logic              timed_out;
   logic              restart;
   logic signed [8:0] sens_pos;
   logic signed [8:0] sens_neg;
   logic signed [8:0] mx;
   logic signed [8:0] my;
   logic [7:0]        joy_new;
   logic [7:0]        nibble_byte;
   logic [7:0]        button_byte;

   // Strobe edge and timeout test; the elapsed time is a signed difference.
   assign level     = item.strobe_value[STROBE_BIT];
   assign elapsed   = item.now - state.start_time;
   assign timed_out = $signed(elapsed) > $signed({16'd0, cfg.phase_timeout});
   assign restart   = (state.phase == PHASE_Y_LOW) || timed_out;

   // Joystick direction thresholds.
   assign sens_pos = $signed({2'b00, cfg.sensitivity});
   assign sens_neg = -sens_pos;
   assign mx       = 9'(item.move_x);
   assign my       = 9'(item.move_y);

   always_comb begin
      joy_new = IDLE_BYTE;
      if (cfg.mouse_attached) begin
         if (mx >= sens_pos) joy_new[2] = 1'b0;
         if (mx <= sens_neg) joy_new[3] = 1'b0;
         if (my >= sens_pos) joy_new[0] = 1'b0;
         if (my <= sens_neg) joy_new[1] = 1'b0;
      end
   end

   // Nibble selected by the current phase.
   always_comb begin
      case (state.phase)
         PHASE_X_HIGH: nibble_byte = {NIBBLE_FILL, state.held_x[7:4]};
         PHASE_X_LOW:  nibble_byte = {NIBBLE_FILL, state.held_x[3:0]};
         PHASE_Y_HIGH: nibble_byte = {NIBBLE_FILL, state.held_y[7:4]};
         default:      nibble_byte = {NIBBLE_FILL, state.held_y[3:0]};
      endcase
   end

   assign button_byte = cfg.mouse_attached ? {BUTTON_FILL, ~item.buttons} : IDLE_BYTE;

   // State update and result selection by request kind.
   always_comb begin
      state_next = state;
      has_result = 1'b0;
      read_data  = button_byte;
      case (item.kind)
         KIND_STROBE: begin
            if (level != state.strobe_level) begin
               state_next.strobe_level = level;
               if (restart) begin
                  if (level) begin
                     state_next.start_time = item.now;
                     state_next.phase      = PHASE_X_HIGH;
                     if (cfg.mouse_attached) begin
                        state_next.held_x = item.move_x;
                        state_next.held_y = item.move_y;
                     end else begin
                        state_next.held_x = 8'd0;
                        state_next.held_y = 8'd0;
                     end
                  end
               end else begin
                  state_next.phase = state.phase + 2'd1;
               end
            end
         end
         KIND_VSYNC: begin
            state_next.joy_valid = 1'b0;
         end
         KIND_MOVE: begin
            has_result = 1'b1;
            if (cfg.joystick_mode) begin
               if (!state.joy_valid) begin
                  state_next.joy_valid = 1'b1;
                  state_next.joy_byte  = joy_new;
                  if (cfg.mouse_attached) begin
                     state_next.held_x = item.move_x;
                     state_next.held_y = item.move_y;
                  end
                  read_data = joy_new;
               end else begin
                  read_data = state.joy_byte;
               end
            end else begin
               read_data = nibble_byte;
            end
         end
         default: begin
            has_result = 1'b1;
            read_data  = button_byte;
         end
      endcase
   end

endmodule

// ----- tb/strobed_mouse_port_tb.sv -----
// Self-checking testbench for the strobed mouse port with its own port predictor.
`timescale 1ns / 100ps

module strobed_mouse_port_tb import spm_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;
   localparam int RANDOM_ITEMS_PER_SETTING = 41;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_kind = KIND_VSYNC;
   logic [7:0]                req_strobe_value = 8'h00;
   logic [31:0]               req_now = 32'd0;
   logic signed [7:0]         req_move_x = 8'sd0;
   logic signed [7:0]         req_move_y = 8'sd0;
   logic [1:0]                req_buttons = 2'd0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_read_data;
   logic                      csr_write = 1'b0;
   logic [1:0]                csr_index = CSR_JOYSTICK_MODE;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // Register mirror, kept in step with every control write.
   logic        cfg_joystick = 1'b0;
   logic [6:0]  cfg_sensitivity = SENSITIVITY_RESET;
   logic        cfg_attached = 1'b1;
   logic [15:0] cfg_timeout = PHASE_TIMEOUT_RESET;

   // Predicted port state.
   logic        pm_level = 1'b0;
   logic [1:0]  pm_phase = PHASE_Y_LOW;
   logic [31:0] pm_start = 32'd0;
   logic [7:0]  pm_held_x = 8'h00;
   logic [7:0]  pm_held_y = 8'h00;
   logic [7:0]  pm_joy_byte = IDLE_BYTE;
   logic        pm_joy_valid = 1'b0;

   logic [7:0]  expected_read_data [$];
   int          failure_count = 0;
   int          send_idle_pct = 29;
   int          recv_idle_pct = 59;
   int          hold_requests = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          cycle_count = 0;

   strobed_mouse_port dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_strobe_value (req_strobe_value),
      .req_now          (req_now),
      .req_move_x       (req_move_x),
      .req_move_y       (req_move_y),
      .req_buttons      (req_buttons),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the predicted state by one accepted request and queues any read result.
   function automatic void predict_port(input kind_type kind, input logic [7:0] value,
                                        input logic [31:0] now,
                                        input logic signed [7:0] mx,
                                        input logic signed [7:0] my,
                                        input logic [1:0] btn);
      logic       level;
      int         elapsed;
      int         mx_i;
      int         my_i;
      int         sens_i;
      logic [7:0] joy;
      logic [7:0] rd;
      level = value[STROBE_BIT];
      case (kind)
         KIND_STROBE: begin
            if (level != pm_level) begin
               pm_level = level;
               // Elapsed time is the signed 32-bit difference to the last start.
               elapsed = int'(now - pm_start);
               if (pm_phase == PHASE_Y_LOW || elapsed > int'(cfg_timeout)) begin
                  if (level) begin
                     pm_start = now;
                     pm_held_x = cfg_attached ? mx : 8'h00;
                     pm_held_y = cfg_attached ? my : 8'h00;
                     pm_phase = PHASE_X_HIGH;
                  end
               end else begin
                  pm_phase = pm_phase + 2'd1;
               end
            end
         end
         KIND_VSYNC: begin
            pm_joy_valid = 1'b0;
         end
         KIND_MOVE: begin
            if (cfg_joystick) begin
               // Only the first movement read after reset or a vsync samples the movement.
               if (!pm_joy_valid) begin
                  joy = IDLE_BYTE;
                  pm_joy_valid = 1'b1;
                  if (cfg_attached) begin
                     pm_held_x = mx;
                     pm_held_y = my;
                     mx_i = int'(mx);
                     my_i = int'(my);
                     sens_i = int'(cfg_sensitivity);
                     // Direction bits are active low: Y in bits 0 and 1, X in bits 2 and 3.
                     if (mx_i >= sens_i) joy[2] = 1'b0;
                     if (mx_i <= -sens_i) joy[3] = 1'b0;
                     if (my_i >= sens_i) joy[0] = 1'b0;
                     if (my_i <= -sens_i) joy[1] = 1'b0;
                  end
                  pm_joy_byte = joy;
               end
               rd = pm_joy_byte;
            end else begin
               case (pm_phase)
                  PHASE_X_HIGH: rd = {NIBBLE_FILL, pm_held_x[7:4]};
                  PHASE_X_LOW:  rd = {NIBBLE_FILL, pm_held_x[3:0]};
                  PHASE_Y_HIGH: rd = {NIBBLE_FILL, pm_held_y[7:4]};
                  default:      rd = {NIBBLE_FILL, pm_held_y[3:0]};
               endcase
            end
            expected_read_data.push_back(rd);
         end
         default: begin
            expected_read_data.push_back(cfg_attached ? {BUTTON_FILL, ~btn} : IDLE_BYTE);
         end
      endcase
   endfunction

   // Offers one request, holds it until accepted, then predicts its effect.
   task automatic send_request(input kind_type kind, input logic [7:0] value,
                               input logic [31:0] now, input logic signed [7:0] mx,
                               input logic signed [7:0] my, input logic [1:0] btn);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_strobe_value <= value;
      req_now <= now;
      req_move_x <= mx;
      req_move_y <= my;
      req_buttons <= btn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_port(kind, value, now, mx, my, btn);
   endtask

   // Stops offering requests and waits until every read result has come back.
   task automatic drain_port;
      req_valid <= 1'b0;
      while (expected_read_data.size() != 0) @(posedge clock);
      // Strobe and vsync requests may still be in flight.
      repeat (4) @(posedge clock);
   endtask

   // Writes all four control registers on consecutive cycles.
   task automatic configure(input logic jm, input logic [6:0] sens, input logic att,
                            input logic [15:0] tmo);
      logic [1:0]                indexes [4];
      logic [CSR_DATA_WIDTH-1:0] values [4];
      indexes = '{CSR_JOYSTICK_MODE, CSR_SENSITIVITY, CSR_MOUSE_ATTACHED, CSR_PHASE_TIMEOUT};
      values = '{CSR_DATA_WIDTH'(jm), CSR_DATA_WIDTH'(sens), CSR_DATA_WIDTH'(att), tmo};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= indexes[i];
         csr_data <= values[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      cfg_joystick = jm;
      cfg_sensitivity = sens;
      cfg_attached = att;
      cfg_timeout = tmo;
   endtask

   // Button reads for every button combination with a mouse attached.
   task automatic test_button_reads;
      for (int b = 0; b < 4; b++) begin
         send_request(KIND_BUTTON, 8'h00, 32'd0, 8'sd0, 8'sd0, 2'(b));
      end
   endtask

   // Nibble sequence: restarts, phase steps, timeout edges and time wraparound.
   task automatic test_nibble_sequence;
      send_request(KIND_STROBE, 8'h40, 32'd1000, 8'h80, 8'h7F, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd1005, 8'h00, 8'h00, 2'd0);
      send_request(KIND_STROBE, 8'hBF, 32'd1010, 8'h11, 8'h22, 2'd3);
      send_request(KIND_MOVE, 8'h00, 32'd1012, 8'h00, 8'h00, 2'd0);
      send_request(KIND_STROBE, 8'hFF, 32'd1020, 8'h00, 8'h00, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd1022, 8'h00, 8'h00, 2'd0);
      send_request(KIND_STROBE, 8'h00, 32'd1030, 8'h00, 8'h00, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd1032, 8'h00, 8'h00, 2'd0);
      // A write that keeps the strobe level does nothing.
      send_request(KIND_STROBE, 8'hBF, 32'd1040, 8'h55, 8'h55, 2'd0);
      send_request(KIND_STROBE, 8'h40, 32'd1050, 8'h5A, 8'hA5, 2'd0);
      // Falling edge after the timeout keeps the phase.
      send_request(KIND_STROBE, 8'h00, 32'd1123, 8'h00, 8'h00, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd1124, 8'h00, 8'h00, 2'd0);
      send_request(KIND_STROBE, 8'h40, 32'd1200, 8'h3C, 8'hC3, 2'd0);
      // Exactly at the timeout the phase still advances.
      send_request(KIND_STROBE, 8'h00, 32'd1272, 8'h00, 8'h00, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd1273, 8'h00, 8'h00, 2'd0);
      // A time stamp far behind the start gives a negative difference.
      send_request(KIND_STROBE, 8'h40, 32'hFFFF_FFF0, 8'h00, 8'h00, 2'd0);
      send_request(KIND_STROBE, 8'h00, 32'hFFFF_FFF8, 8'h00, 8'h00, 2'd0);
      send_request(KIND_STROBE, 8'h40, 32'hFFFF_FFF0, 8'h01, 8'hFE, 2'd0);
      // The difference wraps through zero.
      send_request(KIND_STROBE, 8'h00, 32'h0000_0010, 8'h00, 8'h00, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'h0000_0011, 8'h00, 8'h00, 2'd0);
   endtask

   // Joystick sampling at the largest sensitivity, at zero sensitivity and with no mouse.
   task automatic test_joystick_mode;
      drain_port();
      configure(1'b1, 7'd127, 1'b1, PHASE_TIMEOUT_RESET);
      send_request(KIND_VSYNC, 8'h00, 32'd0, 8'sd0, 8'sd0, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd0, 8'h7F, 8'h80, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd0, 8'h00, 8'h7F, 2'd0);
      send_request(KIND_VSYNC, 8'h00, 32'd0, 8'sd0, 8'sd0, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd0, 8'h81, 8'h00, 2'd0);
      drain_port();
      configure(1'b1, 7'd0, 1'b1, PHASE_TIMEOUT_RESET);
      send_request(KIND_VSYNC, 8'h00, 32'd0, 8'sd0, 8'sd0, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd0, 8'h00, 8'h00, 2'd0);
      drain_port();
      configure(1'b1, 7'd1, 1'b0, PHASE_TIMEOUT_RESET);
      send_request(KIND_VSYNC, 8'h00, 32'd0, 8'sd0, 8'sd0, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'd0, 8'h32, 8'h32, 2'd0);
      send_request(KIND_BUTTON, 8'h00, 32'd0, 8'sd0, 8'sd0, 2'd3);
      drain_port();
      // Without a mouse a restart latches zero movement.
      configure(1'b0, 7'd1, 1'b0, PHASE_TIMEOUT_RESET);
      send_request(KIND_STROBE, 8'h40, 32'h4000_0000, 8'h77, 8'h77, 2'd0);
      send_request(KIND_MOVE, 8'h00, 32'h4000_0001, 8'h00, 8'h00, 2'd0);
   endtask

   // The receiver holds off while reads keep coming, so the request side must stall.
   task automatic test_result_backpressure;
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      hold_requests++;
      for (int i = 0; i < 24; i++) begin
         send_request((i % 2) ? KIND_BUTTON : KIND_MOVE, 8'h00, 32'd0, 8'sd0, 8'sd0, 2'(i));
      end
      send_idle_pct = saved_pct;
   endtask

   // Random traffic under each idling mode and several register settings.
   task automatic test_random_traffic;
      int               count;
      int               pick;
      logic [31:0]      stamp;
      logic [7:0]       value;
      logic signed [7:0] mx;
      logic signed [7:0] my;
      stamp = $urandom;
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 59 : 0;
         recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 29 : 0;
         for (int setting = 0; setting < 4; setting++) begin
            drain_port();
            case (setting)
               0:       configure(1'b0, 7'd1, 1'b1, 16'd0);
               1:       configure(1'b1, 7'd127, 1'b1, 16'hFFFF);
               2:       configure(1'b0, 7'($urandom_range(1, 127)), 1'b1, 16'hFFFF);
               default: configure(1'($urandom_range(1)), 7'($urandom_range(1, 127)),
                                  1'($urandom_range(3) != 0), 16'($urandom));
            endcase
            count = 0;
            while (count < RANDOM_ITEMS_PER_SETTING) begin
               pick = $urandom_range(99);
               mx = 8'($urandom);
               my = 8'($urandom);
               if ($urandom_range(9) == 0) mx = $urandom_range(1) ? 8'h7F : 8'h80;
               if ($urandom_range(9) == 0) my = $urandom_range(1) ? 8'h7F : 8'h80;
               // Time mostly moves in small steps, sometimes in larger steps or anywhere.
               case ($urandom_range(19))
                  0:       stamp = $urandom;
                  1, 2:    stamp = stamp + $urandom_range(41, 400);
                  default: stamp = stamp + $urandom_range(0, 40);
               endcase
               value = 8'($urandom);
               if (pick < 50) begin
                  // Strobe toggle followed by a movement read.
                  value[STROBE_BIT] = ~pm_level;
                  send_request(KIND_STROBE, value, stamp, mx, my, 2'($urandom));
                  send_request(KIND_MOVE, 8'($urandom), stamp, 8'($urandom), 8'($urandom),
                               2'($urandom));
                  count += 2;
               end else if (pick < 65) begin
                  send_request(KIND_VSYNC, value, stamp, 8'($urandom), 8'($urandom),
                               2'($urandom));
                  send_request(KIND_MOVE, 8'($urandom), stamp, mx, my, 2'($urandom));
                  count += 2;
               end else if (pick < 75) begin
                  send_request(KIND_MOVE, value, stamp, mx, my, 2'($urandom));
                  count++;
               end else if (pick < 85) begin
                  send_request(KIND_BUTTON, value, stamp, mx, my, 2'($urandom));
                  count++;
               end else begin
                  // Noise: any kind with fully random fields.
                  send_request(kind_type'($urandom_range(3)), value, $urandom, mx, my,
                               2'($urandom));
                  count++;
               end
            end
         end
      end
   endtask

   // Receiver stall: random, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compares each accepted read result with the oldest prediction.
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_read_data.size() == 0) begin
            failure_count++;
            if (failure_count <= 10) begin
               $display("read result %h arrived with none expected", rsp_read_data);
            end
         end else begin
            want = expected_read_data.pop_front();
            if (rsp_read_data !== want) begin
               failure_count++;
               if (failure_count <= 10) begin
                  $display("read_data mismatch: expected %h, got %h", want, rsp_read_data);
               end
            end
         end
      end
   end

   // Run limit.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_button_reads();
      test_nibble_sequence();
      test_joystick_mode();
      test_result_backpressure();
      test_random_traffic();
      drain_port();
      if (failure_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
